// File: design/wildcard_byte_pattern_search_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wildcard byte pattern search core
// Concurrent assertion wrappers clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_CORE_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_CORE_ASSERT_SVH

// Property checked only while out of reset.
`define WBPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define WBPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/wbps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared widths, register indexes and item kinds for the pattern search core.
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int MAX_NEEDLE = 32;
  localparam int WIN_IDX_W  = $clog2(MAX_NEEDLE);
  localparam int LEN_W      = 6;
  localparam int NIDX_W     = 5;
  localparam int DATA_W     = 8;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef logic [DATA_W-1:0]    data_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_NEEDLE_LENGTH  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_WILDCARD_VALUE = cfg_idx_t'(1);

  localparam logic KIND_NEEDLE   = 1'b0;
  localparam logic KIND_HAYSTACK = 1'b1;

endpackage

// File: design/wildcard_byte_pattern_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search_core
// Streaming leftmost needle search with a wildcard byte value.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): kind 0 loads needle byte needle_index,
// kind 1 streams one haystack byte; final_byte closes the current search.
// Result channel (out_valid / out_stall): one transfer per final haystack byte,
// carrying found and the offset of the leftmost match (0 when not found).
// Config channel (cfg_valid / cfg_ready): index 0 is needle_length, index 1
// is wildcard_value; cfg_ready is always high, write only while idle.
// Throughput: one input transfer per cycle while in_stall is low, needle loads
// and haystack bytes alike. A taken final byte goes into the window register,
// then through the parallel window compare into the result register.
// Stall: a held result keeps its payload; the next final byte waits in the
// window stage and in_stall rises only while that stage is blocked.
// Reset: search state cleared, needle_length 1, wildcard 0; needle bytes are
// undefined until loaded.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_kind,
  input  logic [wbps_pkg::NIDX_W-1:0]      in_needle_index,
  input  logic [wbps_pkg::DATA_W-1:0]      in_data_byte,
  input  logic                             in_final_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_found,
  output logic [wbps_pkg::CNT_W-1:0]       out_match_offset,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_data
);

  wbps_pkg::data_t needle_r [wbps_pkg::MAX_NEEDLE];
  wbps_pkg::data_t window_r [wbps_pkg::MAX_NEEDLE];
  wbps_pkg::len_t  needle_length_r;
  wbps_pkg::data_t wildcard_r;
  wbps_pkg::cnt_t  count_r;
  wbps_pkg::cnt_t  count_nxt;
  logic            fresh_r;
  logic            s1_valid_r;
  logic            s1_final_r;
  logic            match_seen_r;
  logic            match_seen_nxt;
  wbps_pkg::cnt_t  first_r;
  wbps_pkg::cnt_t  first_nxt;
  logic            out_valid_r;
  logic            out_found_r;
  wbps_pkg::cnt_t  out_offset_r;

  wbps_pkg::len_t  len_use;
  logic            window_ok;
  logic            hit;
  logic            out_free;
  logic            s1_take;
  logic            in_take;

  // Clamp the configured length into 1..MAX_NEEDLE.
  always_comb begin
    if (needle_length_r == '0) begin
      len_use = wbps_pkg::len_t'(1);
    end else if (needle_length_r > wbps_pkg::len_t'(wbps_pkg::MAX_NEEDLE)) begin
      len_use = wbps_pkg::len_t'(wbps_pkg::MAX_NEEDLE);
    end else begin
      len_use = needle_length_r;
    end
  end

  // Needle byte i lines up with window entry len-1-i; entries past len pass.
  always_comb begin
    logic [wbps_pkg::WIN_IDX_W-1:0] len_m1;
    logic [wbps_pkg::WIN_IDX_W-1:0] sel;
    logic                           ok;
    len_m1 = wbps_pkg::WIN_IDX_W'(len_use - wbps_pkg::len_t'(1));
    ok     = 1'b1;
    sel    = '0;
    for (int i = 0; i < wbps_pkg::MAX_NEEDLE; i++) begin
      sel = len_m1 - wbps_pkg::WIN_IDX_W'(i);
      if (wbps_pkg::len_t'(i) < len_use) begin
        if (needle_r[i] != wildcard_r && needle_r[i] != window_r[sel]) begin
          ok = 1'b0;
        end
      end
    end
    window_ok = ok;
  end

  assign out_free = !out_valid_r || !out_stall;
  assign s1_take  = s1_valid_r && (!s1_final_r || out_free);
  assign in_stall = s1_valid_r && s1_final_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign hit = !match_seen_r && (count_r >= wbps_pkg::CNT_W'(len_use)) && window_ok;

  always_comb begin
    match_seen_nxt = match_seen_r || hit;
    first_nxt      = hit ? (count_r - wbps_pkg::CNT_W'(len_use)) : first_r;
    // Restart the count after a final byte; saturate at the top.
    count_nxt      = fresh_r ? '0 : count_r;
    if (count_nxt != '1) begin
      count_nxt = count_nxt + wbps_pkg::cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_length_r <= wbps_pkg::len_t'(1);
      wildcard_r      <= '0;
      count_r         <= '0;
      fresh_r         <= 1'b0;
      s1_valid_r      <= 1'b0;
      match_seen_r    <= 1'b0;
      first_r         <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          wbps_pkg::REG_NEEDLE_LENGTH:  needle_length_r <= cfg_data[wbps_pkg::LEN_W-1:0];
          wbps_pkg::REG_WILDCARD_VALUE: wildcard_r      <= cfg_data;
          default: ;
        endcase
      end

      if (in_take && in_kind == wbps_pkg::KIND_HAYSTACK) begin
        count_r    <= count_nxt;
        fresh_r    <= in_final_byte;
        s1_valid_r <= 1'b1;
      end else if (s1_take) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_take) begin
        if (s1_final_r) begin
          match_seen_r <= 1'b0;
          first_r      <= '0;
        end else begin
          match_seen_r <= match_seen_nxt;
          first_r      <= first_nxt;
        end
      end

      if (s1_take && s1_final_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: needle, window, stage flag and result.
  always_ff @(posedge clk) begin
    if (in_take) begin
      if (in_kind == wbps_pkg::KIND_NEEDLE) begin
        if (int'(in_needle_index) < wbps_pkg::MAX_NEEDLE) begin
          needle_r[in_needle_index] <= in_data_byte;
        end
      end else begin
        for (int k = wbps_pkg::MAX_NEEDLE - 1; k > 0; k--) begin
          window_r[k] <= window_r[k-1];
        end
        window_r[0] <= in_data_byte;
        s1_final_r  <= in_final_byte;
      end
    end
    if (s1_take && s1_final_r) begin
      out_found_r  <= match_seen_nxt;
      out_offset_r <= match_seen_nxt ? first_nxt : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_match_offset = out_offset_r;
  assign cfg_ready        = 1'b1;

endmodule

// File: design/wbps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_checker
// Port-level checks of the pattern search core, bound to the top level.
// ----------------------------------------------------------------------------
`include "wildcard_byte_pattern_search_core_assert.svh"

module wbps_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        in_kind,
  input logic                        in_final_byte,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_found,
  input logic [wbps_pkg::CNT_W-1:0]  out_match_offset
);

  logic final_xfer;
  assign final_xfer = in_valid && !in_stall && (in_kind == wbps_pkg::KIND_HAYSTACK)
                      && in_final_byte;

  `WBPS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_found) && $stable(out_match_offset), "stalled result changed")
  `WBPS_ASSERT(a_miss_zero, out_valid && !out_found |-> out_match_offset == '0, "not-found result with nonzero offset")
  `WBPS_ASSERT(a_rise_after_final, $rose(out_valid) |-> $past(final_xfer, 2), "result without a final haystack transfer two cycles back")
  `WBPS_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind wildcard_byte_pattern_search_core wbps_checker u_wbps_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_kind          (in_kind),
  .in_final_byte    (in_final_byte),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_found        (out_found),
  .out_match_offset (out_match_offset)
);
